[rtl/fpa_pkg.sv]
// ----------------------------------------------------------------------------
// fpa_pkg
// Shared types and constants of the fixed-point ALU.
// ----------------------------------------------------------------------------
package fpa_pkg;

    localparam int DATA_BITS     = 32;
    localparam int FUNC_BITS     = 4;
    localparam int FRAC_BITS_DEF = 8;
    localparam int WORD_BITS_DEF = 32;

    typedef enum logic [FUNC_BITS-1:0] {
        FN_ADD      = 4'd0,
        FN_SUB      = 4'd1,
        FN_MUL      = 4'd2,
        FN_DIV      = 4'd3,
        FN_EQ       = 4'd4,
        FN_NE       = 4'd5,
        FN_LT       = 4'd6,
        FN_LE       = 4'd7,
        FN_GT       = 4'd8,
        FN_GE       = 4'd9,
        FN_MIN      = 4'd10,
        FN_MAX      = 4'd11,
        FN_INC      = 4'd12,
        FN_DEC      = 4'd13,
        FN_FROM_INT = 4'd14,
        FN_TO_INT   = 4'd15
    } t_func;

    // Per-beat control carried down the divider chain.
    typedef struct packed {
        logic div;     // quotient is the result
        logic neg;     // negate quotient at the end
        logic flag;
        logic status;
    } t_ctl;

endpackage

[rtl/fpa_if.sv]
// ----------------------------------------------------------------------------
// fpa_req_if / fpa_rsp_if
// Valid/ready channels for operation and result beats.
// ----------------------------------------------------------------------------
interface fpa_req_if import fpa_pkg::*; ();
    logic                        valid;
    logic                        ready;
    logic [FUNC_BITS-1:0]        func;
    logic signed [DATA_BITS-1:0] operand_a;
    logic signed [DATA_BITS-1:0] operand_b;

    modport source (output valid, func, operand_a, operand_b, input ready);
    modport sink   (input valid, func, operand_a, operand_b, output ready);
endinterface

interface fpa_rsp_if import fpa_pkg::*; ();
    logic                        valid;
    logic                        ready;
    logic signed [DATA_BITS-1:0] result;
    logic                        flag;
    logic                        status;

    modport source (output valid, result, flag, status, input ready);
    modport sink   (input valid, result, flag, status, output ready);
endinterface

[rtl/fixed_point_alu.sv]
// ----------------------------------------------------------------------------
// fixed_point_alu
// Signed fixed-point ALU: add, sub, mul, div, compares, min/max, inc/dec,
// integer conversions, on WORD_BITS raw words with FRACTION_BITS fraction bits.
// ----------------------------------------------------------------------------
// Accepts one operation beat per cycle while the result side is ready, and
// returns one result beat per operation, in order. Each beat passes through
// one operand/product stage, a chain of WORD_BITS + FRACTION_BITS division
// cells that each develop one quotient bit, and the output register. All
// operations flow through the same chain, so throughput is one beat per
// cycle under any operation mix as long as o_rsp.ready holds.
module fixed_point_alu import fpa_pkg::*; #(
    parameter int FRACTION_BITS = FRAC_BITS_DEF,
    parameter int WORD_BITS     = WORD_BITS_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    fpa_req_if.sink   i_req,
    fpa_rsp_if.source o_rsp
);

    localparam int W  = WORD_BITS;
    localparam int DW = WORD_BITS + FRACTION_BITS;

    // operand stage
    logic                  r_f_vld;
    t_func                 r_func;
    logic signed [W-1:0]   r_a;
    logic signed [W-1:0]   r_b;
    logic signed [2*W-1:0] r_prod;

    logic signed [W-1:0]   a_in;
    logic signed [W-1:0]   b_in;
    logic signed [2*W-1:0] n_prod;
    logic                  f_rdy;

    // cell chain
    logic          c_vld [0:DW];
    logic          c_rdy [0:DW];
    t_ctl          c_ctl [0:DW];
    logic [W-1:0]  c_res [0:DW];
    logic [W-1:0]  c_rem [0:DW];
    logic [DW-1:0] c_dvd [0:DW];
    logic [W-1:0]  c_dvs [0:DW];

    // output stage
    logic                        r_o_vld;
    logic signed [DATA_BITS-1:0] r_result;
    logic                        r_flag;
    logic                        r_status;
    logic signed [DATA_BITS-1:0] n_result;
    logic signed [W-1:0]         fin;
    logic [DW-1:0]               q_signed;

    assign a_in   = i_req.operand_a[W-1:0];
    assign b_in   = i_req.operand_b[W-1:0];
    assign n_prod = a_in * b_in;
    assign f_rdy  = !r_f_vld || c_rdy[0];
    assign i_req.ready = f_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_vld <= 1'b0;
        end else if (f_rdy) begin
            r_f_vld <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (f_rdy && i_req.valid) begin
            r_func <= t_func'(i_req.func);
            r_a    <= a_in;
            r_b    <= b_in;
            r_prod <= n_prod;
        end
    end

    // decode into the first cell
    logic          lt;
    logic          eq;
    logic [W-1:0]  abs_a;
    logic [W-1:0]  abs_b;
    t_ctl          d_ctl;
    logic [W-1:0]  d_res;
    logic [DW-1:0] d_dvd;
    logic [W-1:0]  d_dvs;

    always_comb begin
        lt    = (r_a < r_b);
        eq    = (r_a == r_b);
        abs_a = r_a[W-1] ? W'(-r_a) : W'(r_a);
        abs_b = r_b[W-1] ? W'(-r_b) : W'(r_b);
        d_ctl = '0;
        d_res = '0;
        d_dvd = DW'(abs_a) << FRACTION_BITS;
        d_dvs = abs_b;
        case (r_func)
            FN_ADD:      d_res = r_a + r_b;
            FN_SUB:      d_res = r_a - r_b;
            FN_MUL:      d_res = r_prod[FRACTION_BITS +: W];
            FN_DIV: begin
                d_ctl.div    = (r_b != '0);
                d_ctl.status = (r_b == '0);
                d_ctl.neg    = r_a[W-1] ^ r_b[W-1];
            end
            FN_EQ:       d_ctl.flag = eq;
            FN_NE:       d_ctl.flag = !eq;
            FN_LT:       d_ctl.flag = lt;
            FN_LE:       d_ctl.flag = lt || eq;
            FN_GT:       d_ctl.flag = !lt && !eq;
            FN_GE:       d_ctl.flag = !lt;
            FN_MIN:      d_res = lt ? r_a : r_b;
            FN_MAX:      d_res = (!lt && !eq) ? r_a : r_b;
            FN_INC:      d_res = r_a + W'(1);
            FN_DEC:      d_res = r_a - W'(1);
            FN_FROM_INT: d_res = r_a << FRACTION_BITS;
            FN_TO_INT:   d_res = W'(r_a >>> FRACTION_BITS);
            default:     d_res = '0;
        endcase
    end

    assign c_vld[0] = r_f_vld;
    assign c_ctl[0] = d_ctl;
    assign c_res[0] = d_res;
    assign c_rem[0] = '0;
    assign c_dvd[0] = d_dvd;
    assign c_dvs[0] = d_dvs;

    for (genvar g = 0; g < DW; g++) begin : g_cell
        fpa_div_cell #(
            .W  (W),
            .DW (DW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_vld   (c_vld[g]),
            .o_rdy   (c_rdy[g]),
            .i_ctl   (c_ctl[g]),
            .i_res   (c_res[g]),
            .i_rem   (c_rem[g]),
            .i_dvd   (c_dvd[g]),
            .i_dvs   (c_dvs[g]),
            .o_vld   (c_vld[g+1]),
            .i_rdy   (c_rdy[g+1]),
            .o_ctl   (c_ctl[g+1]),
            .o_res   (c_res[g+1]),
            .o_rem   (c_rem[g+1]),
            .o_dvd   (c_dvd[g+1]),
            .o_dvs   (c_dvs[g+1])
        );
    end

    assign c_rdy[DW] = !r_o_vld || o_rsp.ready;

    // finish: sign the quotient, wrap, sign-extend
    always_comb begin
        q_signed = c_ctl[DW].neg ? (~c_dvd[DW] + DW'(1)) : c_dvd[DW];
        fin      = c_ctl[DW].div ? q_signed[W-1:0] : c_res[DW];
        n_result = DATA_BITS'(fin);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (c_rdy[DW]) begin
            r_o_vld <= c_vld[DW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_rdy[DW] && c_vld[DW]) begin
            r_result <= n_result;
            r_flag   <= c_ctl[DW].flag;
            r_status <= c_ctl[DW].status;
        end
    end

    assign o_rsp.valid  = r_o_vld;
    assign o_rsp.result = r_result;
    assign o_rsp.flag   = r_flag;
    assign o_rsp.status = r_status;

endmodule

[rtl/fpa_div_cell.sv]
// ----------------------------------------------------------------------------
// fpa_div_cell
// One restoring-division cell: develops one quotient bit per beat and
// hands the beat to the next cell.
// ----------------------------------------------------------------------------
module fpa_div_cell import fpa_pkg::*; #(
    parameter int W  = WORD_BITS_DEF,
    parameter int DW = WORD_BITS_DEF + FRAC_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_vld,
    output logic          o_rdy,
    input  t_ctl          i_ctl,
    input  logic [W-1:0]  i_res,
    input  logic [W-1:0]  i_rem,
    input  logic [DW-1:0] i_dvd,
    input  logic [W-1:0]  i_dvs,
    output logic          o_vld,
    input  logic          i_rdy,
    output t_ctl          o_ctl,
    output logic [W-1:0]  o_res,
    output logic [W-1:0]  o_rem,
    output logic [DW-1:0] o_dvd,
    output logic [W-1:0]  o_dvs
);

    logic          r_vld;
    t_ctl          r_ctl;
    logic [W-1:0]  r_res;
    logic [W-1:0]  r_rem;
    logic [DW-1:0] r_dvd;
    logic [W-1:0]  r_dvs;

    logic [W:0]    trial;
    logic [W:0]    diff;
    logic          qbit;
    logic [W-1:0]  n_rem;
    logic [DW-1:0] n_dvd;

    assign o_rdy = !r_vld || i_rdy;

    always_comb begin
        trial = {i_rem, i_dvd[DW-1]};
        diff  = trial - {1'b0, i_dvs};
        qbit  = (trial >= {1'b0, i_dvs});
        n_rem = qbit ? diff[W-1:0] : trial[W-1:0];
        n_dvd = {i_dvd[DW-2:0], qbit};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_rdy) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rdy && i_vld) begin
            r_ctl <= i_ctl;
            r_res <= i_res;
            r_rem <= n_rem;
            r_dvd <= n_dvd;
            r_dvs <= i_dvs;
        end
    end

    assign o_vld = r_vld;
    assign o_ctl = r_ctl;
    assign o_res = r_res;
    assign o_rem = r_rem;
    assign o_dvd = r_dvd;
    assign o_dvs = r_dvs;

endmodule
